### design/dar_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// DNS A-record extractor package
// Item types, parse phases, result kinds and header offsets shared by the
// parser, the output stage and the top level.
// ----------------------------------------------------------------------------
package dar_pkg;

    // Input item: one frame byte
    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_last;
    } dar_in_t;

    // Result item
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  name_char;
        logic [31:0] ipv4_address;
    } dar_out_t;

    // Result kinds
    localparam logic [1:0] KIND_CHAR     = 2'd0;
    localparam logic [1:0] KIND_NAME_END = 2'd1;
    localparam logic [1:0] KIND_ADDR     = 2'd2;

    // Parse phases
    typedef enum logic [2:0] {
        PH_HDR   = 3'd0,
        PH_QNAME = 3'd1,
        PH_QSKIP = 3'd2,
        PH_QTAIL = 3'd3,
        PH_ANS   = 3'd4,
        PH_DATA  = 3'd5,
        PH_DONE  = 3'd6
    } dar_phase_t;

    // Parser status seen by the top level
    typedef struct packed {
        dar_phase_t phase;
        logic       qualified;
    } dar_status_t;

    // Byte offsets within Ethernet + IPv4 + UDP + DNS header
    localparam logic [5:0] OFS_ETYPE_LO  = 6'd13;
    localparam logic [5:0] OFS_IP_VHL    = 6'd14;
    localparam logic [5:0] OFS_IP_PROTO  = 6'd23;
    localparam logic [5:0] OFS_SPORT_LO  = 6'd35;
    localparam logic [5:0] OFS_DPORT_LO  = 6'd37;
    localparam logic [5:0] OFS_FLAGS_HI  = 6'd44;
    localparam logic [5:0] OFS_QDCOUNT   = 6'd47;
    localparam logic [5:0] OFS_ANCOUNT   = 6'd49;
    localparam logic [5:0] OFS_HDR_END   = 6'd53;

    // Field values
    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [3:0]  IP_IHL_NO_OPTS = 4'd5;
    localparam logic [7:0]  IP_PROTO_UDP   = 8'd17;
    localparam logic [15:0] DNS_PORT_RESET = 16'd53;
    localparam logic [15:0] RR_TYPE_A      = 16'd1;
    localparam logic [15:0] RDLEN_IPV4     = 16'd4;
    localparam logic [7:0]  CHAR_DOT       = 8'h2E;

    // Field positions within question tail and answer record
    localparam logic [3:0] QTAIL_BYTES   = 4'd4;
    localparam logic [3:0] ANS_TYPE_LO   = 4'd3;
    localparam logic [3:0] ANS_RDLEN_LO  = 4'd11;

endpackage
`default_nettype wire

### design/dar_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// DNS A-record parser
// Frame parse state and the single-pass next-state and result logic for one
// accepted byte.
// ----------------------------------------------------------------------------
module dar_parser #(
    parameter int NAME_MAX_CHARS = 255
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             step,
    input  wire dar_pkg::dar_in_t in_item,
    input  wire logic [15:0]      dns_port,
    output logic                  res_valid,
    output dar_pkg::dar_out_t     res_item,
    output dar_pkg::dar_status_t  status
);
    import dar_pkg::*;

    localparam int CW = $clog2(NAME_MAX_CHARS + 1);
    localparam logic [CW-1:0] NAME_MAX = CW'(NAME_MAX_CHARS);

    // state
    logic [5:0]    byte_offset_reg,      byte_offset_next;
    dar_phase_t    phase_reg,            phase_next;
    logic          qualified_reg,        qualified_next;
    logic [15:0]   header_shift_reg,     header_shift_next;
    logic          response_flag_reg,    response_flag_next;
    logic [15:0]   question_count_reg,   question_count_next;
    logic [15:0]   answers_left_reg,     answers_left_next;
    logic [7:0]    label_left_reg,       label_left_next;
    logic          first_label_reg,      first_label_next;
    logic [CW-1:0] chars_emitted_reg,    chars_emitted_next;
    logic [3:0]    field_index_reg,      field_index_next;
    logic [15:0]   record_type_reg,      record_type_next;
    logic [15:0]   data_length_reg,      data_length_next;
    logic [15:0]   data_left_reg,        data_left_next;
    logic [31:0]   addr_acc_reg,         addr_acc_next;

    logic [7:0]  b;
    logic [15:0] shifted;
    logic [15:0] answers_dec;
    logic [15:0] qcount_dec;
    logic [15:0] data_left_dec;
    logic [31:0] acc_shifted;
    logic        show;
    logic        room;

    assign b             = in_item.data_byte;
    assign shifted       = {header_shift_reg[7:0], b};
    assign answers_dec   = answers_left_reg - 16'd1;
    assign qcount_dec    = question_count_reg - 16'd1;
    assign data_left_dec = data_left_reg - 16'd1;
    assign acc_shifted   = {addr_acc_reg[23:0], b};
    assign show          = (phase_reg == PH_QNAME);
    assign room          = (chars_emitted_reg < NAME_MAX);

    // next state and result for one byte
    always_comb
    begin
        byte_offset_next    = byte_offset_reg;
        phase_next          = phase_reg;
        qualified_next      = qualified_reg;
        header_shift_next   = header_shift_reg;
        response_flag_next  = response_flag_reg;
        question_count_next = question_count_reg;
        answers_left_next   = answers_left_reg;
        label_left_next     = label_left_reg;
        first_label_next    = first_label_reg;
        chars_emitted_next  = chars_emitted_reg;
        field_index_next    = field_index_reg;
        record_type_next    = record_type_reg;
        data_length_next    = data_length_reg;
        data_left_next      = data_left_reg;
        addr_acc_next       = addr_acc_reg;
        res_valid           = 1'b0;
        res_item            = '0;

        if (qualified_reg)
        begin
            unique case (phase_reg)
                PH_HDR:
                begin
                    header_shift_next = shifted;
                    byte_offset_next  = byte_offset_reg + 6'd1;
                    unique case (byte_offset_reg)
                        OFS_ETYPE_LO:
                            if (shifted != ETHERTYPE_IPV4) qualified_next = 1'b0;
                        OFS_IP_VHL:
                            if (b[3:0] != IP_IHL_NO_OPTS) qualified_next = 1'b0;
                        OFS_IP_PROTO:
                            if (b != IP_PROTO_UDP) qualified_next = 1'b0;
                        OFS_SPORT_LO:
                            data_length_next = shifted;
                        OFS_DPORT_LO:
                        begin
                            if (data_length_reg != dns_port && shifted != dns_port)
                                qualified_next = 1'b0;
                            data_length_next = '0;
                        end
                        OFS_FLAGS_HI:
                            response_flag_next = b[7];
                        OFS_QDCOUNT:
                            question_count_next = shifted;
                        OFS_ANCOUNT:
                        begin
                            answers_left_next = shifted;
                            if (!response_flag_reg || question_count_reg == '0 ||
                                shifted == '0)
                                qualified_next = 1'b0;
                        end
                        OFS_HDR_END:
                        begin
                            phase_next         = PH_QNAME;
                            first_label_next   = 1'b1;
                            label_left_next    = '0;
                            chars_emitted_next = '0;
                        end
                        default: ;
                    endcase
                end

                PH_QNAME, PH_QSKIP:
                begin
                    if (label_left_reg != '0)
                    begin
                        label_left_next = label_left_reg - 8'd1;
                        if (show && room)
                        begin
                            res_valid              = 1'b1;
                            res_item.kind          = KIND_CHAR;
                            res_item.name_char     = b;
                            chars_emitted_next     = chars_emitted_reg + 1'b1;
                        end
                    end
                    else if (b == '0)
                    begin
                        if (show)
                        begin
                            res_valid     = 1'b1;
                            res_item.kind = KIND_NAME_END;
                        end
                        phase_next       = PH_QTAIL;
                        field_index_next = '0;
                    end
                    else
                    begin
                        label_left_next = b;
                        if (show && !first_label_reg && room)
                        begin
                            res_valid          = 1'b1;
                            res_item.kind      = KIND_CHAR;
                            res_item.name_char = CHAR_DOT;
                            chars_emitted_next = chars_emitted_reg + 1'b1;
                        end
                        first_label_next = 1'b0;
                    end
                end

                // QTYPE and QCLASS
                PH_QTAIL:
                begin
                    field_index_next = field_index_reg + 4'd1;
                    if (field_index_next == QTAIL_BYTES)
                    begin
                        field_index_next    = '0;
                        question_count_next = qcount_dec;
                        if (qcount_dec != '0)
                        begin
                            phase_next      = PH_QSKIP;
                            label_left_next = '0;
                        end
                        else
                            phase_next = PH_ANS;
                    end
                end

                // answer name pointer, TYPE, CLASS, TTL, RDLENGTH
                PH_ANS:
                begin
                    header_shift_next = shifted;
                    if (field_index_reg == ANS_TYPE_LO)
                        record_type_next = shifted;
                    if (field_index_reg == ANS_RDLEN_LO)
                    begin
                        data_length_next = shifted;
                        data_left_next   = shifted;
                        addr_acc_next    = '0;
                        field_index_next = '0;
                        if (shifted == '0)
                        begin
                            answers_left_next = answers_dec;
                            phase_next = (answers_dec != '0) ? PH_ANS : PH_DONE;
                        end
                        else
                            phase_next = PH_DATA;
                    end
                    else
                        field_index_next = field_index_reg + 4'd1;
                end

                PH_DATA:
                begin
                    addr_acc_next  = acc_shifted;
                    data_left_next = data_left_dec;
                    if (data_left_dec == '0)
                    begin
                        if (record_type_reg == RR_TYPE_A && data_length_reg == RDLEN_IPV4)
                        begin
                            res_valid             = 1'b1;
                            res_item.kind         = KIND_ADDR;
                            res_item.ipv4_address = acc_shifted;
                        end
                        answers_left_next = answers_dec;
                        phase_next        = (answers_dec != '0) ? PH_ANS : PH_DONE;
                        field_index_next  = '0;
                    end
                end

                PH_DONE: ;
                default: ;
            endcase
        end

        // end of frame: back to the start state
        if (in_item.frame_last)
        begin
            byte_offset_next    = '0;
            phase_next          = PH_HDR;
            qualified_next      = 1'b1;
            header_shift_next   = '0;
            response_flag_next  = 1'b0;
            question_count_next = '0;
            answers_left_next   = '0;
            label_left_next     = '0;
            first_label_next    = 1'b1;
            chars_emitted_next  = '0;
            field_index_next    = '0;
            record_type_next    = '0;
            data_length_next    = '0;
            data_left_next      = '0;
            addr_acc_next       = '0;
        end
    end

    // state registers, advanced per accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_offset_reg    <= '0;
            phase_reg          <= PH_HDR;
            qualified_reg      <= 1'b1;
            header_shift_reg   <= '0;
            response_flag_reg  <= 1'b0;
            question_count_reg <= '0;
            answers_left_reg   <= '0;
            label_left_reg     <= '0;
            first_label_reg    <= 1'b1;
            chars_emitted_reg  <= '0;
            field_index_reg    <= '0;
            record_type_reg    <= '0;
            data_length_reg    <= '0;
            data_left_reg      <= '0;
            addr_acc_reg       <= '0;
        end
        else if (step)
        begin
            byte_offset_reg    <= byte_offset_next;
            phase_reg          <= phase_next;
            qualified_reg      <= qualified_next;
            header_shift_reg   <= header_shift_next;
            response_flag_reg  <= response_flag_next;
            question_count_reg <= question_count_next;
            answers_left_reg   <= answers_left_next;
            label_left_reg     <= label_left_next;
            first_label_reg    <= first_label_next;
            chars_emitted_reg  <= chars_emitted_next;
            field_index_reg    <= field_index_next;
            record_type_reg    <= record_type_next;
            data_length_reg    <= data_length_next;
            data_left_reg      <= data_left_next;
            addr_acc_reg       <= addr_acc_next;
        end
    end

    assign status.phase     = phase_reg;
    assign status.qualified = qualified_reg;

endmodule
`default_nettype wire

### design/dar_out_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// DNS A-record output stage
// Result register with valid/ready; takes a new item whenever the held one
// is empty or leaving this cycle.
// ----------------------------------------------------------------------------
module dar_out_stage (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step,
    input  wire logic              res_valid,
    input  wire dar_pkg::dar_out_t res_item,
    output logic                   take,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output dar_pkg::dar_out_t      out_item
);
    import dar_pkg::*;

    logic     valid_reg, valid_next;
    dar_out_t item_reg;

    // room for a new item when empty or draining
    assign take = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (step)
            valid_next = res_valid;
        else if (out_ready)
            valid_next = 1'b0;
    end

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (step && res_valid)
            item_reg <= res_item;
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule
`default_nettype wire

### design/dns_a_record_extractor.sv
`default_nettype none
// ----------------------------------------------------------------------------
// DNS A-record extractor
// Parses Ethernet frames byte by byte and reports DNS response names and
// type-A answer addresses.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one frame byte per item, frame_last on the final byte of a frame.
//   out_* : at most one result item per input item: a name character or dot,
//           a name-end mark, or an IPv4 address.
//   cfg_we/cfg_wdata : sets the UDP port matched as DNS (53 after reset);
//           write only while no frame is in progress.
// Throughput: one input item per cycle, sustained while out_ready stays high.
// Latency: a result appears on out_* the cycle after the byte that caused it
//   is accepted; the parse state and the result register are both updated at
//   that edge.
// Stall: in_ready drops only while a result is held and out_ready is low,
//   so a stalled receiver stops the input after one held item.
// Reset: clears the parse to the start of a frame and empties the result
//   register; dns_port returns to 53.
// ----------------------------------------------------------------------------
module dns_a_record_extractor #(
    parameter int NAME_MAX_CHARS = 255
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire dar_pkg::dar_in_t  in_item,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output dar_pkg::dar_out_t      out_item,
    input  wire logic              cfg_we,
    input  wire logic [15:0]       cfg_wdata
);
    import dar_pkg::*;

    logic        dns_port_reg;
    logic [15:0] port_reg;
    logic        step;
    logic        res_valid;
    dar_out_t    res_item;
    dar_status_t status;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            port_reg <= DNS_PORT_RESET;
        else if (cfg_we)
            port_reg <= cfg_wdata;
    end

    // marks that a port write has been seen since reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dns_port_reg <= 1'b0;
        else if (cfg_we)
            dns_port_reg <= 1'b1;
    end

    assign step = in_valid && in_ready;

    dar_parser #(
        .NAME_MAX_CHARS (NAME_MAX_CHARS)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .in_item   (in_item),
        .dns_port  (port_reg),
        .res_valid (res_valid),
        .res_item  (res_item),
        .status    (status)
    );

    dar_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .res_valid (res_valid),
        .res_item  (res_item),
        .take      (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    // a frame end always returns the parser to the header phase
    a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
        (step && in_item.frame_last) |=> (status.phase == PH_HDR && status.qualified))
        else $error("parser not reset after frame end");

    // no result from a rejected frame
    a_reject_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (step && !status.qualified) |=> !($rose(out_valid)) || !$past(step))
        else $error("result from rejected frame");

    // unused payload fields stay zero
    a_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_item.kind != KIND_CHAR) |-> (out_item.name_char == '0))
        else $error("name_char nonzero outside character item");

    a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_item.kind != KIND_ADDR) |-> (out_item.ipv4_address == '0))
        else $error("address nonzero outside address item");

    // the port keeps its reset value until a write has been seen
    a_port_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!dns_port_reg) |-> (port_reg == DNS_PORT_RESET))
        else $error("dns port changed without a write");

endmodule
`default_nettype wire

### verif/dns_a_record_extractor_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// DNS A-record extractor testbench
// Streams Ethernet frames into the extractor one byte per item: hand-built
// DNS responses, frames with one flaw in the header, truncated frames and
// noise. A byte-level model of the parser predicts the name characters,
// name-end marks and A-record addresses, which are checked in order
// against the result channel. The DNS port register is rewritten between
// phases, with both sides idling and stalling at random.
// ----------------------------------------------------------------------------
module dns_a_record_extractor_tb;

    import dar_pkg::*;

    localparam int NAME_LIMIT   = 255;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_BYTES  = 40;
    localparam int FLAW_CUT     = 56;
    localparam int TIMEOUT_NS   = 2_000_000;
    localparam int SHOWN_ERRORS = 10;

    // Ways a frame header is spoiled
    localparam int FLAW_NONE   = 0;
    localparam int FLAW_ETYPE  = 1;
    localparam int FLAW_IHL    = 2;
    localparam int FLAW_PROTO  = 3;
    localparam int FLAW_PORTS  = 4;
    localparam int FLAW_QUERY  = 5;
    localparam int FLAW_NO_QD  = 6;
    localparam int FLAW_NO_AN  = 7;

    localparam logic [15:0] RR_TYPE_CNAME = 16'd5;

    // ------------------------------------------------------------------------
    // Parser model and result checking
    // ------------------------------------------------------------------------
    class dns_extract_model;
        bit [15:0]  dns_port;
        bit [15:0]  byte_ofs;
        dar_phase_t phase;
        bit         qualified;
        bit [15:0]  shift_reg;
        bit         is_response;
        bit [15:0]  questions_left;
        bit [15:0]  answers_left;
        bit [7:0]   label_left;
        bit         first_label;
        int         chars_out;
        bit [3:0]   field_idx;
        bit [15:0]  rr_type;
        bit [15:0]  rd_length;
        bit [15:0]  rd_left;
        bit [31:0]  addr_acc;
        dar_out_t   name_addr_queue[$];
        int         mismatches;

        function new();
            dns_port   = DNS_PORT_RESET;
            mismatches = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            byte_ofs       = '0;
            phase          = PH_HDR;
            qualified      = 1'b1;
            shift_reg      = '0;
            is_response    = 1'b0;
            questions_left = '0;
            answers_left   = '0;
            label_left     = '0;
            first_label    = 1'b1;
            chars_out      = 0;
            field_idx      = '0;
            rr_type        = '0;
            rd_length      = '0;
            rd_left        = '0;
            addr_acc       = '0;
        endfunction

        function void close_answer();
            answers_left = answers_left - 16'd1;
            phase        = (answers_left != 0) ? PH_ANS : PH_DONE;
            field_idx    = '0;
        endfunction

        // Advance by one accepted byte; returns 1 if the frame was still live
        function bit note_byte(dar_in_t it);
            bit [7:0] b;
            bit       live;
            bit       show;
            bit       emit;
            dar_out_t res;
            b    = it.data_byte;
            live = qualified;
            emit = 1'b0;
            res  = '0;
            if (qualified)
            begin
                case (phase)
                    PH_HDR:
                    begin
                        shift_reg = {shift_reg[7:0], b};
                        case (byte_ofs)
                            OFS_ETYPE_LO: if (shift_reg != ETHERTYPE_IPV4) qualified = 1'b0;
                            OFS_IP_VHL:   if (b[3:0] != IP_IHL_NO_OPTS) qualified = 1'b0;
                            OFS_IP_PROTO: if (b != IP_PROTO_UDP) qualified = 1'b0;
                            OFS_SPORT_LO: rd_length = shift_reg;
                            OFS_DPORT_LO:
                            begin
                                if (rd_length != dns_port && shift_reg != dns_port)
                                    qualified = 1'b0;
                                rd_length = '0;
                            end
                            OFS_FLAGS_HI: is_response = b[7];
                            OFS_QDCOUNT:  questions_left = shift_reg;
                            OFS_ANCOUNT:
                            begin
                                answers_left = shift_reg;
                                if (!is_response || questions_left == 0 || answers_left == 0)
                                    qualified = 1'b0;
                            end
                            OFS_HDR_END:
                            begin
                                phase       = PH_QNAME;
                                first_label = 1'b1;
                                label_left  = '0;
                                chars_out   = 0;
                            end
                            default: ;
                        endcase
                        if (byte_ofs != 16'hFFFF) byte_ofs++;
                    end
                    PH_QNAME, PH_QSKIP:
                    begin
                        show = (phase == PH_QNAME);
                        if (label_left != 0)
                        begin
                            label_left--;
                            if (show && chars_out < NAME_LIMIT)
                            begin
                                emit          = 1'b1;
                                res.kind      = KIND_CHAR;
                                res.name_char = b;
                                chars_out++;
                            end
                        end
                        else if (b == 8'd0)
                        begin
                            if (show)
                            begin
                                emit     = 1'b1;
                                res.kind = KIND_NAME_END;
                            end
                            phase     = PH_QTAIL;
                            field_idx = '0;
                        end
                        else
                        begin
                            label_left = b;
                            // dot between labels, subject to the same truncation
                            if (show && !first_label && chars_out < NAME_LIMIT)
                            begin
                                emit          = 1'b1;
                                res.kind      = KIND_CHAR;
                                res.name_char = CHAR_DOT;
                                chars_out++;
                            end
                            first_label = 1'b0;
                        end
                    end
                    PH_QTAIL:
                    begin
                        field_idx++;
                        if (field_idx == QTAIL_BYTES)
                        begin
                            field_idx      = '0;
                            questions_left = questions_left - 16'd1;
                            if (questions_left != 0)
                            begin
                                phase      = PH_QSKIP;
                                label_left = '0;
                            end
                            else
                                phase = PH_ANS;
                        end
                    end
                    PH_ANS:
                    begin
                        shift_reg = {shift_reg[7:0], b};
                        if (field_idx == ANS_TYPE_LO) rr_type = shift_reg;
                        if (field_idx == ANS_RDLEN_LO)
                        begin
                            rd_length = shift_reg;
                            rd_left   = shift_reg;
                            addr_acc  = '0;
                            field_idx = '0;
                            if (rd_length == 0) close_answer();
                            else phase = PH_DATA;
                        end
                        else
                            field_idx++;
                    end
                    PH_DATA:
                    begin
                        addr_acc = {addr_acc[23:0], b};
                        rd_left  = rd_left - 16'd1;
                        if (rd_left == 0)
                        begin
                            if (rr_type == RR_TYPE_A && rd_length == RDLEN_IPV4)
                            begin
                                emit             = 1'b1;
                                res.kind         = KIND_ADDR;
                                res.ipv4_address = addr_acc;
                            end
                            close_answer();
                        end
                    end
                    default: ;
                endcase
            end
            if (emit) name_addr_queue.push_back(res);
            if (it.frame_last) clear_frame();
            return live;
        endfunction

        function void check_result(dar_out_t got);
            dar_out_t want;
            if (name_addr_queue.size() == 0)
            begin
                mismatches++;
                if (mismatches <= SHOWN_ERRORS)
                    $display("unexpected result: kind %0d char %h addr %h",
                             got.kind, got.name_char, got.ipv4_address);
                return;
            end
            want = name_addr_queue.pop_front();
            if (got.kind != want.kind || got.name_char != want.name_char ||
                got.ipv4_address != want.ipv4_address)
            begin
                mismatches++;
                if (mismatches <= SHOWN_ERRORS)
                    $display({"mismatch: expected kind %0d char %h addr %h, ",
                              "got kind %0d char %h addr %h"},
                             want.kind, want.name_char, want.ipv4_address,
                             got.kind, got.name_char, got.ipv4_address);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and block
    // ------------------------------------------------------------------------
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    dar_in_t     in_item = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    dar_out_t    out_item;
    logic        cfg_we = 1'b0;
    logic [15:0] cfg_wdata = '0;

    always #1 clk = ~clk;

    dns_a_record_extractor #(
        .NAME_MAX_CHARS(NAME_LIMIT)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    dns_extract_model model;
    bit [7:0]         frame_bytes[$];
    int               live_bytes;
    bit               tx_steady;
    bit               rx_steady = 1'b0;
    int               rx_hold = 0;

    // Result receiver: ready in runs, short stalls mostly, a few long ones
    always @(posedge clk)
    begin
        if (rx_steady)
            out_ready <= 1'b1;
        else if (rx_hold > 0)
            rx_hold <= rx_hold - 1;
        else if ($urandom_range(0, 99) < 60)
        begin
            out_ready <= 1'b1;
            rx_hold   <= $urandom_range(0, 6);
        end
        else
        begin
            out_ready <= 1'b0;
            rx_hold   <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
                                                     : $urandom_range(0, 2);
        end
    end

    // Result check
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            model.check_result(out_item);
    end

    // ------------------------------------------------------------------------
    // Frame building
    // ------------------------------------------------------------------------
    function automatic void push8(bit [7:0] v);
        frame_bytes.push_back(v);
    endfunction

    function automatic void push16(bit [15:0] v);
        push8(v[15:8]);
        push8(v[7:0]);
    endfunction

    function automatic void push_rand(int n);
        repeat (n) push8(8'($urandom_range(0, 255)));
    endfunction

    function automatic void push_label(int len);
        push8(8'(len));
        push_rand(len);
    endfunction

    // Ethernet, IPv4 and UDP headers plus the 12-byte DNS header
    function automatic void push_header(bit [15:0] etype, bit [7:0] vhl, bit [7:0] proto,
                                        bit [15:0] sport, bit [15:0] dport,
                                        bit [15:0] flags, bit [15:0] qd, bit [15:0] an);
        push_rand(12);
        push16(etype);
        push8(vhl);
        push_rand(8);
        push8(proto);
        push_rand(10);
        push16(sport);
        push16(dport);
        push_rand(6);
        push16(flags);
        push16(qd);
        push16(an);
        push_rand(4);
    endfunction

    // Question name with random label lengths, then type and class
    function automatic void push_question(int labels, int lo, int hi);
        for (int i = 0; i < labels; i++)
            push_label($urandom_range(lo, hi));
        push8(8'd0);
        push_rand(4);
    endfunction

    // Answer up to RDATA; caller appends rd_len bytes
    function automatic void push_answer_head(bit [15:0] rr, bit [15:0] rd_len);
        push16(($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535)) : 16'hC00C);
        push16(rr);
        push_rand(6);
        push16(rd_len);
    endfunction

    function automatic bit [15:0] other_port();
        return model.dns_port ^ 16'($urandom_range(1, 65535));
    endfunction

    function automatic bit [3:0] nibble_except(bit [3:0] v);
        bit [3:0] n;
        n = 4'($urandom_range(0, 14));
        return (n >= v) ? n + 4'd1 : n;
    endfunction

    // DNS response with random content, optionally with one header flaw
    function automatic void build_dns_frame(int qd, int an, int flaw, bit wide_name);
        bit [15:0] etype;
        bit [7:0]  vhl;
        bit [7:0]  proto;
        bit [15:0] sport;
        bit [15:0] dport;
        bit [15:0] flags;
        bit [15:0] rr;
        bit [15:0] rd_len;
        int        pick;
        etype = ETHERTYPE_IPV4;
        vhl   = {4'($urandom_range(0, 15)), IP_IHL_NO_OPTS};
        proto = IP_PROTO_UDP;
        flags = 16'h8000 | 16'($urandom_range(0, 32767));
        pick  = $urandom_range(0, 2);
        sport = (pick == 1) ? other_port() : model.dns_port;
        dport = (pick == 0) ? other_port() : model.dns_port;
        case (flaw)
            FLAW_ETYPE: etype = ETHERTYPE_IPV4 ^ 16'($urandom_range(1, 65535));
            FLAW_IHL:   vhl   = {4'($urandom_range(0, 15)), nibble_except(IP_IHL_NO_OPTS)};
            FLAW_PROTO: proto = IP_PROTO_UDP ^ 8'($urandom_range(1, 255));
            FLAW_PORTS:
            begin
                sport = other_port();
                dport = other_port();
            end
            FLAW_QUERY: flags[15] = 1'b0;
            default: ;
        endcase
        push_header(etype, vhl, proto, sport, dport, flags,
                    (flaw == FLAW_NO_QD) ? 16'd0 : 16'(qd),
                    (flaw == FLAW_NO_AN) ? 16'd0 : 16'(an));
        for (int q = 0; q < qd; q++)
        begin
            if (wide_name && q == 0)
                push_question($urandom_range(2, 4), 50, 255);
            else if ($urandom_range(0, 9) == 0)
                push_question($urandom_range(1, 2), 60, 70);
            else
                push_question($urandom_range(0, 4), 1, 12);
        end
        for (int a = 0; a < an; a++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 65)
            begin
                rr     = RR_TYPE_A;
                rd_len = ($urandom_range(0, 99) < 85) ? RDLEN_IPV4 : 16'($urandom_range(0, 8));
            end
            else
            begin
                case (pick % 4)
                    0:       rr = RR_TYPE_CNAME;
                    1:       rr = 16'd28;
                    2:       rr = 16'd0;
                    default: rr = 16'($urandom_range(0, 65535));
                endcase
                rd_len = ($urandom_range(0, 9) == 0) ? RDLEN_IPV4 : 16'($urandom_range(0, 16));
            end
            push_answer_head(rr, rd_len);
            push_rand(rd_len);
        end
        push_rand($urandom_range(0, 6));
    endfunction

    // ------------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(6, 24);
    endfunction

    task automatic drive_byte(bit [7:0] b, bit last);
        dar_in_t nxt;
        int      gap;
        gap = tx_steady ? 0 : pick_gap();
        repeat (gap)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        nxt.data_byte  = b;
        nxt.frame_last = last;
        in_valid <= 1'b1;
        in_item  <= nxt;
        do @(posedge clk); while (!(in_valid && in_ready));
        if (model.note_byte(nxt)) live_bytes++;
    endtask

    // Send the built frame, ending it early at byte count cut when nonzero
    task automatic send_frame(int cut);
        int n;
        n = frame_bytes.size();
        if (cut > 0 && cut < n) n = cut;
        tx_steady = ($urandom_range(0, 4) == 0);
        rx_steady <= ($urandom_range(0, 4) == 0);
        for (int i = 0; i < n; i++)
            drive_byte(frame_bytes[i], i == n - 1);
        frame_bytes.delete();
    endtask

    // Let the block drain before touching the port register
    task automatic settle();
        in_valid <= 1'b0;
        while (model.name_addr_queue.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_port(bit [15:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        model.dns_port = v;
    endtask

    task automatic directed_frames();
        // three labels, A answers at the address extremes, then a CNAME
        push_header(ETHERTYPE_IPV4, 8'h05, IP_PROTO_UDP, other_port(), model.dns_port,
                    16'h8180, 16'd1, 16'd3);
        push_label(3);
        push_label(7);
        push_label(3);
        push8(8'd0);
        push_rand(4);
        push_answer_head(RR_TYPE_A, RDLEN_IPV4);
        push16(16'hFFFF);
        push16(16'hFFFF);
        push_answer_head(RR_TYPE_A, RDLEN_IPV4);
        push16(16'h0000);
        push16(16'h0000);
        push_answer_head(RR_TYPE_CNAME, 16'd3);
        push_rand(3);
        send_frame(0);

        // empty name, second question with a long label skipped, odd answers
        push_header(ETHERTYPE_IPV4, 8'hF5, IP_PROTO_UDP, model.dns_port, other_port(),
                    16'hFFFF, 16'd2, 16'd4);
        push8(8'd0);
        push_rand(4);
        push_label(64);
        push8(8'd0);
        push_rand(4);
        push_answer_head(RR_TYPE_A, 16'd0);
        push_answer_head(RR_TYPE_A, 16'd5);
        push_rand(5);
        push_answer_head(16'hFFFF, RDLEN_IPV4);
        push_rand(4);
        push_answer_head(RR_TYPE_A, RDLEN_IPV4);
        push_rand(4);
        push_rand(5);
        send_frame(0);

        // name longer than the character limit
        push_header(ETHERTYPE_IPV4, 8'h45, IP_PROTO_UDP, model.dns_port, model.dns_port,
                    16'h8000, 16'd1, 16'd1);
        push_label(250);
        push_label(10);
        push_label(1);
        push8(8'd0);
        push_rand(4);
        push_answer_head(RR_TYPE_A, RDLEN_IPV4);
        push_rand(4);
        send_frame(0);

        // frames cut short in the header and in the question, then a one-byte frame
        build_dns_frame(1, 1, FLAW_NONE, 1'b0);
        send_frame(40);
        build_dns_frame(1, 1, FLAW_NONE, 1'b0);
        send_frame(58);
        push8(8'hFF);
        send_frame(0);

        // each header check failing once, a few bytes past the DNS header
        for (int f = FLAW_ETYPE; f <= FLAW_NO_AN; f++)
        begin
            build_dns_frame(1, 1, f, 1'b0);
            send_frame(FLAW_CUT);
        end
    endtask

    task automatic random_frame();
        int r;
        int cut;
        r   = $urandom_range(0, 99);
        cut = 0;
        if (r < 65)
        begin
            build_dns_frame(($urandom_range(0, 3) == 0) ? $urandom_range(2, 3) : 1,
                            $urandom_range(1, 4), FLAW_NONE, 1'b0);
            if ($urandom_range(0, 99) < 12) cut = $urandom_range(1, frame_bytes.size() - 1);
        end
        else if (r < 80)
            build_dns_frame(1, 1, $urandom_range(FLAW_ETYPE, FLAW_NO_AN), 1'b0);
        else if (r < 92)
            push_rand($urandom_range(1, 80));
        else if (r < 94)
            build_dns_frame(1, $urandom_range(1, 2), FLAW_NONE, 1'b1);
        else
        begin
            build_dns_frame(1, 1, FLAW_NONE, 1'b0);
            cut = $urandom_range(1, 54);
        end
        send_frame(cut);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        bit [15:0] port_plan[5];
        model        = new();
        port_plan[0] = DNS_PORT_RESET;
        port_plan[1] = 16'h0000;
        port_plan[2] = 16'hFFFF;
        port_plan[3] = 16'($urandom_range(0, 65535));
        port_plan[4] = DNS_PORT_RESET;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int ph = 0; ph < 5; ph++)
        begin
            if (ph > 0)
            begin
                settle();
                write_port(port_plan[ph]);
            end
            if (ph == 0) directed_frames();
            live_bytes = 0;
            while (live_bytes < PHASE_BYTES) random_frame();
        end
        settle();

        if (model.mismatches == 0 && model.name_addr_queue.size() == 0)
            $display("dns_a_record_extractor_tb passed");
        else
            $display("dns_a_record_extractor_tb failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #(TIMEOUT_NS);
        $display("dns_a_record_extractor_tb failed");
        $finish;
    end

endmodule
